// File: hdl/lsg_pkg.sv
// ----------------------------------------------------------------------------
// lsg_pkg
// Shared types and constants of the lookup-table sine waveform generator.
// ----------------------------------------------------------------------------
package lsg_pkg;

  localparam int DATA_W             = 16;
  localparam int CFG_IDX_W          = 1;
  localparam int TABLE_SIZE_DEFAULT = 1000;

  localparam logic [DATA_W-1:0] FULL_SCALE   = 16'hFFFF;
  localparam logic [DATA_W-1:0] AMP_RESET    = 16'hFFFF;
  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd100;

  // pi/2 in unsigned Q60.
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 1'd1;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ROM,
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/lsg_if.sv
// ----------------------------------------------------------------------------
// lsg_if
// Valid/ready channels of the sine waveform generator: commands in, samples out.
// ----------------------------------------------------------------------------
interface lsg_in_if import lsg_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  logic enable_value;

  modport source (output valid, output cmd, output enable_value, input ready);
  modport sink   (input valid, input cmd, input enable_value, output ready);
endinterface

interface lsg_out_if import lsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/lut_sine_waveform_generator.sv
// ----------------------------------------------------------------------------
// lut_sine_waveform_generator
// Tick-driven sine generator: a phase counter picks an entry of a sine ROM,
// which is scaled by the amplitude register. Index and scaling run through
// one bit-serial shift-add multiplier and one restoring divider.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                 Transfer
// in_ch    in   cmd, enable_value       valid && ready
// out_ch   out  sample[15:0]            valid && ready
// cfg_*    in   cfg_index, cfg_data     cfg_we
//
// A running tick runs two passes of 16 multiplier and 32 divider steps, with a ROM
// read and an operand load between them; it then raises the output valid and frees
// the input in the same cycle.
// A stopping enable command shows its zero sample in the cycle after the transfer;
// ticks while stopped are taken without a sample. Reset is synchronous, the ROM is constant.
// A waiting sample blocks only enable commands; a computed sample holds the sequencer.
// ----------------------------------------------------------------------------
module lut_sine_waveform_generator import lsg_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lsg_in_if.sink               in_ch,
  lsg_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int PROD_W = 2 * DATA_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [CNT_W-1:0]  MUL_LAST = CNT_W'(DATA_W - 1);
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(PROD_W - 1);
  localparam logic [63:0]       TBL_N    = 64'(TABLE_SIZE);
  localparam logic [63:0]       TH_STEP  = HALF_PI_Q60 / TBL_N;
  localparam logic [63:0]       TH_REM   = HALF_PI_Q60 % TBL_N;
  localparam logic [PROD_W-1:0] TBL_PROD = PROD_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(TABLE_SIZE - 1);

  typedef logic [DATA_W-1:0] rom_t [TABLE_SIZE];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  function automatic logic [63:0] quarter_sin(input logic [63:0] u);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sum;
    th   = TH_STEP * u + (TH_REM * u) / TBL_N;
    th2  = mul_q60(th, th);
    term = th;
    sum  = th;
    term = mul_q60(term, th2) / 64'd6;   sum = sum - term;
    term = mul_q60(term, th2) / 64'd20;  sum = sum + term;
    term = mul_q60(term, th2) / 64'd42;  sum = sum - term;
    term = mul_q60(term, th2) / 64'd72;  sum = sum + term;
    term = mul_q60(term, th2) / 64'd110; sum = sum - term;
    term = mul_q60(term, th2) / 64'd156; sum = sum + term;
    term = mul_q60(term, th2) / 64'd210; sum = sum - term;
    term = mul_q60(term, th2) / 64'd272; sum = sum + term;
    term = mul_q60(term, th2) / 64'd342; sum = sum - term;
    term = mul_q60(term, th2) / 64'd420; sum = sum + term;
    term = mul_q60(term, th2) / 64'd506; sum = sum - term;
    term = mul_q60(term, th2) / 64'd600; sum = sum + term;
    if (sum > (64'd1 << 60)) begin
      sum = 64'd1 << 60;
    end
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] q4;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] base;
    logic [63:0] tot;
    logic [63:0] entry;
    base = 64'd65535 << 44;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      q4 = 64'd4 * 64'(i);
      q  = q4 / TBL_N;
      r  = q4 - q * TBL_N;
      s  = q[0] ? quarter_sin(TBL_N - r) : quarter_sin(r);
      y  = 64'd65535 * (s >> 16);
      tot   = (q >= 64'd2) ? (base - y) : (base + y);
      entry = (tot + (64'd1 << 44)) >> 45;
      rom[i] = entry[DATA_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pass_r, pass_nxt;
  logic                running_r, running_nxt;
  logic [DATA_W-1:0]   phase_count_r, phase_count_nxt;
  logic [DATA_W-1:0]   amplitude_r;
  logic [DATA_W-1:0]   period_r;
  logic [PROD_W-1:0]   acc_r, acc_nxt;
  logic [PROD_W-1:0]   mc_r, mc_nxt;
  logic [DATA_W-1:0]   mp_r, mp_nxt;
  logic [PROD_W-1:0]   q_r, q_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   div_r, div_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [DATA_W-1:0]   rom_q_r;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_sample_r, out_sample_nxt;

  logic                in_ready;
  logic                in_fire;
  logic [DATA_W-1:0]   period_eff;
  logic [DATA_W-1:0]   phase_eff;
  logic [PROD_W-1:0]   acc_sum;
  logic [DATA_W:0]     rem_shift;
  logic [DATA_W:0]     rem_diff;
  logic                rem_ge;
  logic [DATA_W-1:0]   rem_step;
  logic [PROD_W-1:0]   q_step;
  logic [IDX_W-1:0]    idx_clamp;

  assign in_ready = (state_r == ST_IDLE) &&
                    (in_ch.cmd == CMD_TICK || !out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;

  assign in_ch.ready   = in_ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  assign period_eff = (period_r == '0) ? DATA_W'(1) : period_r;
  assign phase_eff  = (phase_count_r >= period_eff) ? '0 : phase_count_r;

  assign acc_sum   = acc_r + (mp_r[0] ? mc_r : '0);
  assign rem_shift = {rem_r, q_r[PROD_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_r};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign rem_step  = rem_ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
  assign q_step    = {q_r[PROD_W-2:0], rem_ge};
  assign idx_clamp = (q_step >= TBL_PROD) ? IDX_MAX : q_step[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      pass_r        <= 1'b0;
      running_r     <= 1'b0;
      phase_count_r <= '0;
      amplitude_r   <= AMP_RESET;
      period_r      <= PERIOD_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      pass_r        <= pass_nxt;
      running_r     <= running_nxt;
      phase_count_r <= phase_count_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_AMPLITUDE: amplitude_r <= cfg_data;
          REG_PERIOD:    period_r    <= cfg_data;
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    mc_r         <= mc_nxt;
    mp_r         <= mp_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    idx_r        <= idx_nxt;
    rom_q_r      <= SINE_ROM[idx_r];
    out_sample_r <= out_sample_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pass_nxt        = pass_r;
    running_nxt     = running_r;
    phase_count_nxt = phase_count_r;
    acc_nxt         = acc_r;
    mc_nxt          = mc_r;
    mp_nxt          = mp_r;
    q_nxt           = q_r;
    rem_nxt         = rem_r;
    div_nxt         = div_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd == CMD_ENABLE) begin
            running_nxt = in_ch.enable_value ? !running_r : 1'b0;
            if (!running_nxt) begin
              out_valid_nxt  = 1'b1;
              out_sample_nxt = '0;
            end
          end else if (running_r) begin
            phase_count_nxt = phase_eff + DATA_W'(1);
            mc_nxt          = TBL_PROD;
            mp_nxt          = phase_eff;
            acc_nxt         = '0;
            div_nxt         = period_eff;
            cnt_nxt         = '0;
            pass_nxt        = 1'b0;
            state_nxt       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_nxt = acc_sum;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == MUL_LAST) begin
          q_nxt     = acc_sum;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt = '0;
          if (!pass_r) begin
            idx_nxt   = idx_clamp;
            state_nxt = ST_ROM;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ROM: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        mc_nxt    = {{(PROD_W-DATA_W){1'b0}}, rom_q_r};
        mp_nxt    = amplitude_r;
        acc_nxt   = '0;
        div_nxt   = FULL_SCALE;
        cnt_nxt   = '0;
        pass_nxt  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = q_r[DATA_W-1:0];
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/lsg_checker.sv
// ----------------------------------------------------------------------------
// lsg_checker
// Port-level checks of the sine waveform generator, bound to its top level.
// ----------------------------------------------------------------------------
module lsg_checker import lsg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_cmd,
  input logic              in_enable_value,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_sample
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready;

  // A held sample must not change before its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output sample dropped or changed while stalled");

  // A forced stop answers with a zero sample on the next cycle.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_cmd == CMD_ENABLE && !in_enable_value |=>
      out_valid && out_sample == '0)
    else $error("forced stop did not produce a zero sample");

  // A tick never yields its sample in the very next cycle.
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_cmd == CMD_TICK |=> !$rose(out_valid))
    else $error("tick produced a sample too early");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lut_sine_waveform_generator lsg_checker u_lsg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .in_enable_value (in_ch.enable_value),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_sample      (out_ch.sample)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the lookup-table sine waveform generator.
// Commands go in through a bursty sender while the sample receiver stalls on
// its own pattern. Every accepted command is run through a cycle-free model of
// the generator that rebuilds the sine table with exact integer arithmetic and
// queues the expected samples. Each received sample is compared against the
// oldest queued one. Directed cases cover stopped ticks, start and stop, period
// shrink, register extremes and one long output stall, followed by randomized
// phases under varying amplitude and period settings.
// ----------------------------------------------------------------------------
module tb;
  import lsg_pkg::*;

  localparam int          ROM_DEPTH     = TABLE_SIZE_DEFAULT;
  localparam int          ROM_IDX_W     = $clog2(ROM_DEPTH);
  localparam logic [63:0] PI_HALF_Q60   = 64'h1921FB54442D1847;
  localparam logic [31:0] AMP_FULL      = 32'hFFFF;
  localparam int          SETTLE_CYCLES = 120;
  localparam int          LONG_HOLD     = 600;
  localparam int          RANDOM_ITEMS  = 750;
  localparam int          CYCLE_LIMIT   = 1000000;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  lsg_in_if  in_ch ();
  lsg_out_if out_ch ();

  lut_sine_waveform_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [15:0]       sine_rom [ROM_DEPTH];
  logic [DATA_W-1:0] expected_samples [$];
  logic [15:0]       gen_amplitude;
  logic [15:0]       gen_period;
  logic [15:0]       gen_phase;
  logic              gen_running;
  int                fail_count;
  int                burst_left;
  int                gap_max;
  int                hold_requests;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[123:60];
  endfunction

  // sin(pi/2 * u / ROM_DEPTH) in Q60 from a truncated Taylor series.
  function automatic logic [63:0] quarter_wave(logic [63:0] u);
    logic [63:0] n, th, th2, term, acc;
    int k;
    n = 64'(ROM_DEPTH);
    th = (PI_HALF_Q60 / n) * u + ((PI_HALF_Q60 % n) * u) / n;
    th2 = q60_mul(th, th);
    term = th;
    acc = th;
    for (k = 1; k <= 12; k++) begin
      term = q60_mul(term, th2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > (64'd1 << 60)) begin
      acc = 64'd1 << 60;
    end
    return acc;
  endfunction

  function automatic void build_sine_rom();
    logic [63:0] n, q, r, s, y, base, tot;
    int i;
    n = 64'(ROM_DEPTH);
    base = 64'd65535 << 44;
    for (i = 0; i < ROM_DEPTH; i++) begin
      q = 64'(4 * i) / n;
      r = 64'(4 * i) - q * n;
      s = q[0] ? quarter_wave(n - r) : quarter_wave(r);
      y = 64'd65535 * (s >> 16);
      tot = (q >= 2) ? base - y : base + y;
      tot = (tot + (64'd1 << 44)) >> 45;
      sine_rom[i] = tot[15:0];
    end
  endfunction

  function automatic void predict_generator(logic cmd_bit, logic en_bit);
    logic [15:0] per;
    logic [31:0] idx, level;
    if (cmd_bit == CMD_TICK) begin
      if (!gen_running) begin
        return;
      end
      per = (gen_period == 16'd0) ? 16'd1 : gen_period;
      if (gen_phase >= per) begin
        gen_phase = 16'd0;
      end
      idx = (32'(gen_phase) * 32'(ROM_DEPTH)) / 32'(per);
      if (idx >= 32'(ROM_DEPTH)) begin
        idx = 32'(ROM_DEPTH - 1);
      end
      level = (32'(gen_amplitude) * 32'(sine_rom[idx[ROM_IDX_W-1:0]])) / AMP_FULL;
      expected_samples.push_back(level[DATA_W-1:0]);
      gen_phase = gen_phase + 16'd1;
    end else begin
      gen_running = en_bit ? !gen_running : 1'b0;
      if (!gen_running) begin
        expected_samples.push_back('0);
      end
    end
  endfunction

  task automatic send_item(input logic cmd_bit, input logic en_bit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= cmd_bit;
    in_ch.enable_value <= en_bit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_generator(cmd_bit, en_bit);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_waveform(input logic [15:0] amp, input logic [15:0] per);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AMPLITUDE;
    cfg_data  <= amp;
    @(posedge clk);
    cfg_index <= REG_PERIOD;
    cfg_data  <= per;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_amplitude = amp;
    gen_period    = per;
  endtask

  function automatic logic [15:0] pick_amplitude();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(100, 5000));
      default: return 16'($urandom_range(2, 64));
    endcase
  endfunction

  task automatic test_stopped_ticks();
    send_item(CMD_TICK, 1'b0);
    send_item(CMD_TICK, 1'b1);
    send_item(CMD_ENABLE, 1'b0);
  endtask

  task automatic test_start_stop();
    int i;
    send_item(CMD_ENABLE, 1'b1);
    for (i = 0; i < 10; i++) begin
      send_item(CMD_TICK, 1'(i % 2));
    end
    send_item(CMD_ENABLE, 1'b1);
    send_item(CMD_ENABLE, 1'b1);
    repeat (2) send_item(CMD_TICK, 1'b0);
  endtask

  // The phase stays past the new, shorter period and must wrap on the next tick.
  task automatic test_period_shrink();
    settle_block();
    set_waveform(16'hFFFF, 16'd5);
    repeat (2) send_item(CMD_TICK, 1'b1);
  endtask

  task automatic test_register_extremes();
    settle_block();
    set_waveform(16'd0, 16'd0);
    repeat (2) send_item(CMD_TICK, 1'b0);
    settle_block();
    set_waveform(16'hFFFF, 16'hFFFF);
    repeat (2) send_item(CMD_TICK, 1'b0);
    send_item(CMD_ENABLE, 1'b0);
  endtask

  task automatic test_output_backpressure();
    settle_block();
    set_waveform(16'd50000, 16'd20);
    if (!gen_running) begin
      send_item(CMD_ENABLE, 1'b1);
    end
    gap_max = 0;
    hold_requests++;
    repeat (12) send_item(CMD_TICK, 1'b0);
    drain_results();
  endtask

  task automatic test_random_sequences();
    int counted, steps;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle_block();
      set_waveform(pick_amplitude(), pick_period());
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      steps = $urandom_range(20, 60);
      repeat (steps) begin
        if (gen_running) begin
          if ($urandom_range(0, 99) < 88) begin
            send_item(CMD_TICK, 1'($urandom_range(0, 1)));
          end else begin
            send_item(CMD_ENABLE, 1'($urandom_range(0, 1)));
          end
          counted++;
        end else begin
          case ($urandom_range(0, 4))
            0: send_item(CMD_TICK, 1'($urandom_range(0, 1)));
            1: begin
              send_item(CMD_ENABLE, 1'b0);
              counted++;
            end
            default: begin
              send_item(CMD_ENABLE, 1'b1);
              counted++;
            end
          endcase
        end
      end
    end
  endtask

  initial begin : sample_receiver
    rx_mode_t mode;
    int span, hold_left, holds_seen, beat;
    out_ch.ready <= 1'b0;
    mode = RX_STEADY;
    span = 0;
    hold_left = 0;
    holds_seen = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        span = $urandom_range(20, 200);
      end
      span--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          default:   out_ch.ready <= (beat % 4 == 0);
        endcase
      end
    end
  end

  initial begin : sample_checker
    logic [DATA_W-1:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          note_failure($sformatf("Unexpected sample %0d with nothing pending.",
                                 out_ch.sample));
        end else begin
          want = expected_samples.pop_front();
          if (out_ch.sample !== want) begin
            note_failure($sformatf("Sample mismatch: expected %0d, got %0d.",
                                   want, out_ch.sample));
          end
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : test_sequence
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.cmd          <= CMD_TICK;
    in_ch.enable_value <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_AMPLITUDE;
    cfg_data           <= '0;
    gen_amplitude = AMP_RESET;
    gen_period    = PERIOD_RESET;
    gen_phase     = 16'd0;
    gen_running   = 1'b0;
    fail_count    = 0;
    burst_left    = 0;
    gap_max       = 8;
    hold_requests = 0;
    build_sine_rom();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stopped_ticks();
    test_start_stop();
    test_period_shrink();
    test_register_extremes();
    test_output_backpressure();
    test_random_sequences();
    settle_block();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
